@@ rtl/core/brs_pkg.sv @@
// Package for the bounded random sampler: twister constants, the tempering
// function and the sequencer state type. No dependencies.
`timescale 1ns / 1ps

package brs_pkg;

    localparam int TW_WORDS = 312;
    localparam int TW_MID   = 156;
    localparam int IDX_W    = $clog2(TW_WORDS + 1);
    localparam int RANGE_W  = 31;

    localparam logic [63:0] TW_MATRIX = 64'hB502_6F5A_A966_19E9;
    localparam logic [63:0] TW_UPPER  = 64'hFFFF_FFFF_8000_0000;
    localparam logic [63:0] TW_LOWER  = 64'h0000_0000_7FFF_FFFF;
    localparam logic [63:0] SEED_MULT = 64'd6364136223846793005;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SEED0,
        ST_SD_M0,
        ST_SD_M1,
        ST_SD_M2,
        ST_SD_WR,
        ST_TW_A,
        ST_TW_B,
        ST_TW_C,
        ST_TW_D,
        ST_DR_RD,
        ST_DR_TEMP,
        ST_DR_MLO,
        ST_DR_MHI,
        ST_DR_CHK,
        ST_OUT
    } brs_state_t;

    function automatic logic [63:0] temper(input logic [63:0] w);
        logic [63:0] x;
        x = w;
        x = x ^ ((x >> 29) & 64'h5555_5555_5555_5555);
        x = x ^ ((x << 17) & 64'h71D6_7FFF_EDA6_0000);
        x = x ^ ((x << 37) & 64'hFFF7_EEE0_0000_0000);
        x = x ^ (x >> 43);
        return x;
    endfunction

endpackage

@@ rtl/core/brs_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module brs_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 312
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

@@ rtl/core/bounded_random_sampler.sv @@
// Bounded random sampler: MT19937-64 words in a RAM, multiply-and-reject
// mapping to 1..range_size. Depends on brs_pkg and brs_ram.
//
// Each draw reads a word, tempers it, multiplies it by range_size in two
// halves and rejects it if the low 64 bits of the product are below the
// threshold; a twist runs when all 312 words are used. The first draw of a
// call reseeds the words from the seed, then twists. Throughput is set by the
// single RAM read port and the shared 32x32 multiplier. Reset (aresetn,
// synchronous) opens no call, so the next transfer reseeds; range_size returns to 1.
`timescale 1ns / 1ps

module bounded_random_sampler (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [30:0] cfg_wr_data,     // range_size
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,    // [63:0] seed
    input  logic        s_axis_tlast,    // last_draw
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,    // [30:0] sample, [31] zero
    output logic        m_axis_tlast     // last_out
);

    import brs_pkg::*;

    brs_state_t state_reg, state_next;

    logic [RANGE_W-1:0] range_reg;
    logic               call_open_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic [IDX_W-1:0]   cnt_reg;
    logic               last_reg;
    logic [63:0]        seed_reg;
    logic [63:0]        p_reg;
    logic [63:0]        m0_reg;
    logic [31:0]        m1_reg, m2_reg;
    logic [63:0]        cur_reg, nx_reg;
    logic [63:0]        x_reg;
    logic [63:0]        pl_reg, ph_reg;
    logic [RANGE_W-1:0] sample_reg;
    logic               out_valid_reg;
    logic [RANGE_W-1:0] out_sample_reg;
    logic               out_last_reg;

    // threshold divider
    logic [RANGE_W-1:0] div_s_reg;
    logic [RANGE_W-1:0] rem_reg;
    logic [63:0]        dvd_reg;
    logic [6:0]         div_cnt_reg;
    logic               div_start;

    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr, ram_raddr;
    logic [63:0]        ram_wdata, ram_rdata;

    logic [31:0]        mul_a, mul_b;
    logic [63:0]        mul_p;

    logic [63:0]        seed_a;
    logic [63:0]        seed_new;
    logic [63:0]        tw_y, tw_v;
    logic [63:0]        lo_sum;
    logic               lo_carry;
    logic [63:0]        hi_sum;
    logic [63:0]        threshold;
    logic               in_xfer, out_load;
    logic [IDX_W-1:0]   cnt_p1, cnt_mid;

    brs_ram #(.WIDTH(64), .DEPTH(TW_WORDS)) u_words (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    assign in_xfer   = s_axis_tvalid && s_axis_tready;
    assign out_load  = (state_reg == ST_OUT) && (!out_valid_reg || m_axis_tready);
    assign threshold = {{(64 - RANGE_W){1'b0}}, rem_reg};

    assign seed_a   = p_reg ^ (p_reg >> 62);
    assign seed_new = m0_reg + {m1_reg + m2_reg, 32'd0}
                    + {{(64 - IDX_W){1'b0}}, cnt_reg};

    assign cnt_p1  = (cnt_reg == IDX_W'(TW_WORDS - 1)) ? '0 : cnt_reg + 1'b1;
    assign cnt_mid = (cnt_reg < IDX_W'(TW_MID)) ? cnt_reg + IDX_W'(TW_MID)
                                                : cnt_reg - IDX_W'(TW_MID);

    assign tw_y = (cur_reg & TW_UPPER) | (nx_reg & TW_LOWER);
    assign tw_v = ram_rdata ^ (tw_y >> 1) ^ (tw_y[0] ? TW_MATRIX : 64'd0);

    assign lo_sum   = pl_reg + {ph_reg[31:0], 32'd0};
    assign lo_carry = (lo_sum < pl_reg);
    assign hi_sum   = {32'd0, ph_reg[63:32]} + {63'd0, lo_carry};

    // shared 32x32 multiplier
    always_comb begin
        mul_a = x_reg[31:0];
        mul_b = {1'b0, range_reg};
        case (state_reg)
            ST_SD_M0: begin
                mul_a = seed_a[31:0];
                mul_b = SEED_MULT[31:0];
            end
            ST_SD_M1: begin
                mul_a = seed_a[63:32];
                mul_b = SEED_MULT[31:0];
            end
            ST_SD_M2: begin
                mul_a = seed_a[31:0];
                mul_b = SEED_MULT[63:32];
            end
            ST_DR_MHI: begin
                mul_a = x_reg[63:32];
            end
            default: begin
            end
        endcase
    end
    assign mul_p = mul_a * mul_b;

    always_comb begin
        state_next = state_reg;
        ram_we     = 1'b0;
        ram_waddr  = cnt_reg;
        ram_wdata  = seed_new;
        ram_raddr  = cnt_reg;
        div_start  = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (in_xfer) begin
                    if (!call_open_reg) begin
                        div_start  = 1'b1;
                        state_next = ST_SEED0;
                    end else if (idx_reg == IDX_W'(TW_WORDS)) begin
                        state_next = ST_TW_A;
                    end else begin
                        state_next = ST_DR_RD;
                    end
                end
            end
            ST_SEED0: begin
                ram_we     = 1'b1;
                ram_waddr  = '0;
                ram_wdata  = seed_reg;
                state_next = ST_SD_M0;
            end
            ST_SD_M0: state_next = ST_SD_M1;
            ST_SD_M1: state_next = ST_SD_M2;
            ST_SD_M2: state_next = ST_SD_WR;
            ST_SD_WR: begin
                ram_we     = 1'b1;
                state_next = (cnt_reg == IDX_W'(TW_WORDS - 1)) ? ST_TW_A : ST_SD_M0;
            end
            ST_TW_A: begin
                state_next = ST_TW_B;
            end
            ST_TW_B: begin
                ram_raddr  = cnt_p1;
                state_next = ST_TW_C;
            end
            ST_TW_C: begin
                ram_raddr  = cnt_mid;
                state_next = ST_TW_D;
            end
            ST_TW_D: begin
                ram_we     = 1'b1;
                ram_wdata  = tw_v;
                state_next = (cnt_reg == IDX_W'(TW_WORDS - 1)) ? ST_DR_RD : ST_TW_A;
            end
            ST_DR_RD: begin
                ram_raddr  = idx_reg;
                state_next = ST_DR_TEMP;
            end
            ST_DR_TEMP: state_next = ST_DR_MLO;
            ST_DR_MLO:  state_next = ST_DR_MHI;
            ST_DR_MHI:  state_next = ST_DR_CHK;
            ST_DR_CHK: begin
                if (lo_sum < threshold) begin
                    state_next = (idx_reg == IDX_W'(TW_WORDS)) ? ST_TW_A : ST_DR_RD;
                end else begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign s_axis_tready = (state_reg == ST_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            range_reg     <= RANGE_W'(1);
            call_open_reg <= 1'b0;
            idx_reg       <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                range_reg <= (cfg_wr_data == '0) ? RANGE_W'(1) : cfg_wr_data;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (in_xfer && call_open_reg && idx_reg == IDX_W'(TW_WORDS)) begin
                        cnt_reg <= '0;
                    end
                end
                ST_SEED0: cnt_reg <= IDX_W'(1);
                ST_SD_WR: begin
                    if (cnt_reg == IDX_W'(TW_WORDS - 1)) begin
                        idx_reg       <= IDX_W'(TW_WORDS);
                        call_open_reg <= 1'b1;
                        cnt_reg       <= '0;
                    end else begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                ST_TW_D: begin
                    if (cnt_reg == IDX_W'(TW_WORDS - 1)) begin
                        idx_reg <= '0;
                        cnt_reg <= '0;
                    end else begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                ST_DR_RD: idx_reg <= idx_reg + 1'b1;
                ST_DR_CHK: begin
                    if (lo_sum < threshold && idx_reg == IDX_W'(TW_WORDS)) begin
                        cnt_reg <= '0;
                    end
                end
                ST_OUT: begin
                    if (out_load) begin
                        out_valid_reg <= 1'b1;
                        if (last_reg) begin
                            call_open_reg <= 1'b0;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            last_reg <= s_axis_tlast;
            seed_reg <= s_axis_tdata;
        end
        case (state_reg)
            ST_SEED0:   p_reg  <= seed_reg;
            ST_SD_M0:   m0_reg <= mul_p;
            ST_SD_M1:   m1_reg <= mul_p[31:0];
            ST_SD_M2:   m2_reg <= mul_p[31:0];
            ST_SD_WR:   p_reg  <= seed_new;
            ST_TW_B:    cur_reg <= ram_rdata;
            ST_TW_C:    nx_reg  <= ram_rdata;
            ST_DR_TEMP: x_reg  <= temper(ram_rdata);
            ST_DR_MLO:  pl_reg <= mul_p;
            ST_DR_MHI:  ph_reg <= mul_p;
            ST_DR_CHK:  sample_reg <= hi_sum[RANGE_W-1:0] + 1'b1;
            default: begin
            end
        endcase
        if (out_load) begin
            out_sample_reg <= sample_reg;
            out_last_reg   <= last_reg;
        end
    end

    // threshold (2^64 - s) mod s, one quotient bit per cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rem_reg     <= '0;
            div_cnt_reg <= '0;
        end else if (div_start) begin
            rem_reg     <= '0;
            div_s_reg   <= range_reg;
            dvd_reg     <= 64'd0 - {{(64 - RANGE_W){1'b0}}, range_reg};
            div_cnt_reg <= 7'd64;
        end else if (div_cnt_reg != '0) begin
            if ({rem_reg, dvd_reg[63]} >= {1'b0, div_s_reg}) begin
                rem_reg <= RANGE_W'({rem_reg, dvd_reg[63]} - {1'b0, div_s_reg});
            end else begin
                rem_reg <= {rem_reg[RANGE_W-2:0], dvd_reg[63]};
            end
            dvd_reg     <= dvd_reg << 1;
            div_cnt_reg <= div_cnt_reg - 1'b1;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, out_sample_reg};
    assign m_axis_tlast  = out_last_reg;

    a_div_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DR_CHK) |-> (div_cnt_reg == '0))
        else $error("threshold not ready at draw check");

    a_idx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        idx_reg <= IDX_W'(TW_WORDS))
        else $error("twister index out of range");

    a_seed_word0: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SD_WR) |-> (cnt_reg != '0))
        else $error("seed fill overwrites word zero");

    a_call_close: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && last_reg) |=> !call_open_reg)
        else $error("call left open after last draw");

endmodule

@@ test/brs_checker.sv @@
// Checker for the bounded random sampler: watches both stream channels and the
// range register port, predicts each sample with its own MT19937-64 and compares.
`timescale 1ns / 1ps

module brs_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [30:0] cfg_wr_data,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,
    input  logic        s_axis_tlast,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [31:0] m_axis_tdata,
    input  logic        m_axis_tlast,
    output int          fail_count,
    output int          pending_samples
);
    import brs_pkg::*;

    typedef struct packed {
        logic [30:0] sample;
        logic        last_out;
    } sample_t;

    logic [63:0] mt_words [TW_WORDS];
    int          mt_pos;
    logic [63:0] cut_level;
    logic        call_live;
    logic [30:0] cur_range;
    sample_t     sample_queue[$];

    assign pending_samples = sample_queue.size();

    task automatic report(input string what);
        fail_count++;
        $display("mismatch at %0t: %s", $realtime, what);
    endtask

    function automatic logic [63:0] mt_word();
        logic [63:0] y, v;
        if (mt_pos >= TW_WORDS) begin
            for (int i = 0; i < TW_WORDS; i++) begin
                y = (mt_words[i] & TW_UPPER) | (mt_words[(i + 1) % TW_WORDS] & TW_LOWER);
                v = mt_words[(i + TW_MID) % TW_WORDS] ^ (y >> 1);
                if (y[0]) v = v ^ TW_MATRIX;
                mt_words[i] = v;
            end
            mt_pos = 0;
        end
        v = mt_words[mt_pos];
        mt_pos++;
        v = v ^ ((v >> 29) & 64'h5555_5555_5555_5555);
        v = v ^ ((v << 17) & 64'h71D6_7FFF_EDA6_0000);
        v = v ^ ((v << 37) & 64'hFFF7_EEE0_0000_0000);
        v = v ^ (v >> 43);
        return v;
    endfunction

    function automatic sample_t draw_sample(input logic [63:0] seed, input logic last);
        logic [63:0]  s, p;
        logic [127:0] prod;
        sample_t      r;
        s = {33'd0, cur_range};
        if (!call_live) begin
            mt_words[0] = seed;
            for (int i = 1; i < TW_WORDS; i++) begin
                p = mt_words[i - 1];
                mt_words[i] = SEED_MULT * (p ^ (p >> 62)) + 64'(i);
            end
            mt_pos = TW_WORDS;
            cut_level = (64'd0 - s) % s;
            call_live = 1'b1;
        end
        prod = {64'd0, mt_word()} * {64'd0, s};
        while (prod[63:0] < cut_level)
            prod = {64'd0, mt_word()} * {64'd0, s};
        r.sample = prod[94:64] + 31'd1;
        r.last_out = last;
        if (last) call_live = 1'b0;
        return r;
    endfunction

    always @(posedge aclk) begin
        sample_t want;
        if (!aresetn) begin
            mt_pos = 0;
            cut_level = 0;
            call_live = 1'b0;
            cur_range = 31'd1;
            sample_queue.delete();
        end else begin
            if (cfg_wr_en) cur_range = (cfg_wr_data == 0) ? 31'd1 : cfg_wr_data;
            if (s_axis_tvalid && s_axis_tready)
                sample_queue.insert(sample_queue.size(),
                    draw_sample(s_axis_tdata, s_axis_tlast));
            if (m_axis_tvalid && m_axis_tready) begin
                if (sample_queue.size() == 0) begin
                    report("sample with none expected");
                end else begin
                    want = sample_queue.pop_front();
                    if (m_axis_tdata[30:0] !== want.sample)
                        report($sformatf("sample %0d, want %0d", m_axis_tdata[30:0],
                            want.sample));
                    if (m_axis_tdata[31] !== 1'b0) report("pad bit set");
                    if (m_axis_tlast !== want.last_out)
                        report($sformatf("tlast %b, want %b", m_axis_tlast, want.last_out));
                end
            end
        end
    end

    initial fail_count = 0;
endmodule

@@ test/tb_bounded_random_sampler.sv @@
// Top of the bounded random sampler bench: clock, reset, range writes and
// seed stimulus; brs_checker does the prediction. Needs brs_pkg and the RTL.
`timescale 1ns / 1ps

module tb_bounded_random_sampler;
    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [30:0] cfg_wr_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata = '0;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic        m_axis_tlast;
    int          fail_count;
    int          pending_samples;
    int          cycle_count = 0;
    int          idle_pct = 36;
    bit          hold_off = 1'b0;

    localparam int CYCLE_LIMIT = 4_000_000;

    bounded_random_sampler u_top (.*);
    brs_checker u_chk (.*);

    initial forever #4 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Receiver: random stalls, or a long hold-off when asked.
    always @(negedge aclk)
        m_axis_tready <= !hold_off && ($urandom_range(99) >= idle_pct);

    // tvalid is set directly so that a drop and a raise at the same edge
    // settle on the raise.
    task automatic send_draw(input logic [63:0] seed, input logic last);
        while ($urandom_range(99) < idle_pct) @(negedge aclk);
        s_axis_tvalid = 1'b1;
        s_axis_tdata  <= seed;
        s_axis_tlast  <= last;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        @(negedge aclk);
        s_axis_tvalid = 1'b0;
    endtask

    task automatic set_range(input logic [30:0] value);
        while (pending_samples != 0) @(negedge aclk);
        repeat (20) @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [63:0] rand_seed();
        return {$urandom(), $urandom()};
    endfunction

    function automatic logic [30:0] rand_range();
        case ($urandom_range(3))
            0: return 31'($urandom_range(1, 10));
            1: return 31'($urandom_range(11, 100000));
            2: return 31'h7FFF_FFFF - 31'($urandom_range(1000));
            default: return 31'($urandom());
        endcase
    endfunction

    initial begin
        int sent;
        int len;
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        // Directed: reset range, seed extremes, zero range, range extremes.
        send_draw(64'd0, 1'b0);
        send_draw(64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
        set_range(31'd0);
        send_draw(64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
        send_draw(64'd5, 1'b1);
        set_range(31'h7FFF_FFFF);
        for (int i = 0; i < 4; i++) send_draw(64'hAAAA_5555_AAAA_5555, i == 3);
        set_range(31'h4000_0001);
        for (int i = 0; i < 5; i++) send_draw(64'h5555_AAAA_5555_AAAA, i == 4);
        set_range(31'd6);
        send_draw(64'h8000_0000_0000_0001, 1'b0);
        // Range change within an open call.
        set_range(31'd1000);
        for (int i = 0; i < 3; i++) send_draw(rand_seed(), i == 2);
        set_range(31'd3);
        // Back-pressure: keep offering while the receiver holds off.
        fork
            begin
                hold_off <= 1'b1;
                repeat (3000) @(negedge aclk);
                hold_off <= 1'b0;
            end
            for (int i = 0; i < 6; i++) send_draw(rand_seed(), i == 5);
        join
        sent = 0;
        while (sent < 450) begin
            if ($urandom_range(3) == 0) set_range(rand_range());
            if (sent > 150 && sent < 250) idle_pct = 0;
            else idle_pct = 36;
            // Calls are long so reseeds stay a minority of the run.
            len = $urandom_range(1, 40);
            for (int i = 0; i < len; i++) begin
                send_draw(rand_seed(), i == len - 1);
                sent++;
            end
        end
        while (pending_samples != 0) @(negedge aclk);
        repeat (50) @(negedge aclk);
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule

@@ files.f @@
rtl/core/brs_pkg.sv
rtl/core/brs_ram.sv
rtl/core/bounded_random_sampler.sv
test/brs_checker.sv
test/tb_bounded_random_sampler.sv
